// ----- src/pra_pkg.sv -----
// pra_pkg: shared constants, codes and types for the power-of-two range allocator
// depends on nothing; used by pow2_range_allocator and its checker
package pra_pkg;

  localparam int SEGMENT_SIZE_DEF = 65536;
  localparam int MAX_SEGMENTS_DEF = 16;
  localparam int FREE_DEPTH_DEF   = 64;
  localparam int OWNER_DEPTH_DEF  = 64;

  localparam int POS_W  = 21;
  localparam int ID_W   = 32;
  localparam int CNT_W  = 16;
  localparam int STAT_W = 3;
  localparam int PCS_W  = 5;

  localparam logic [CNT_W-1:0] MIN_PIECE = 16'd64;
  localparam logic [CNT_W-1:0] MAX_PIECE = 16'd32768;

  typedef enum logic [STAT_W-1:0] {
    ST_REUSED     = 3'd0,
    ST_FREE_LIST  = 3'd1,
    ST_GROWN      = 3'd2,
    ST_TOO_LARGE  = 3'd3,
    ST_TABLE_FULL = 3'd4,
    ST_EXHAUSTED  = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_OSCAN,
    S_DECIDE,
    S_FSCAN,
    S_PLACE,
    S_COUNT,
    S_CHECK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_APPEND,
    S_SPLIT,
    S_OWRITE,
    S_DONE
  } state_t;

  function automatic logic [CNT_W-1:0] round_pow2(input logic [CNT_W-1:0] cnt);
    logic [CNT_W-1:0] r;
    r = MIN_PIECE;
    for (int k = 6; k < 15; k++) begin
      if (cnt > (CNT_W'(1) << k)) r = CNT_W'(1) << (k + 1);
    end
    return r;
  endfunction

endpackage

// ----- src/pow2_range_allocator.sv -----
// pow2_range_allocator: owner table and ordered free list of power-of-two ranges
// depends on pra_pkg; owner table and free list live in synchronous memories
//
// usage:
//   request channel: in_valid/in_stall with owner_id and element_count. one
//   transaction is taken while the block is idle; in_stall is high while it works.
//   result channel: out_valid/out_stall with range_start, range_end,
//   granted_vertices, granted_indices and status. the result sits in an output
//   register, so a new request is taken while a result still waits.
//   work per request: the owner table is scanned one entry a cycle, ending early
//   at a hit; then the free list is scanned, the split pieces are counted, the
//   free list entries behind a taken entry are moved down one at a time, and the
//   split pieces are appended. each memory has a single read port, through which
//   the scans and the moves go. too-large requests go straight from idle to the
//   done state.
//   reset: the free list holds one segment starting at zero, the pool ends after
//   one segment, no owner is valid; no clearing pass is needed.
//   a stalled result holds; the block finishes its work and waits in its last
//   state until the output register is free.
module pow2_range_allocator #(
  parameter int SEGMENT_SIZE = pra_pkg::SEGMENT_SIZE_DEF,
  parameter int MAX_SEGMENTS = pra_pkg::MAX_SEGMENTS_DEF,
  parameter int FREE_DEPTH   = pra_pkg::FREE_DEPTH_DEF,
  parameter int OWNER_DEPTH  = pra_pkg::OWNER_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [pra_pkg::ID_W-1:0]    owner_id,
  input  logic [pra_pkg::CNT_W-1:0]   element_count,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [pra_pkg::POS_W-1:0]   range_start,
  output logic [pra_pkg::POS_W-1:0]   range_end,
  output logic [pra_pkg::CNT_W-1:0]   granted_vertices,
  output logic [pra_pkg::CNT_W-1:0]   granted_indices,
  output logic [pra_pkg::STAT_W-1:0]  status
);

  localparam int PW   = pra_pkg::POS_W;
  localparam int IW   = pra_pkg::ID_W;
  localparam int OAW  = $clog2(OWNER_DEPTH);
  localparam int OCW  = $clog2(OWNER_DEPTH + 1);
  localparam int FAW  = $clog2(FREE_DEPTH);
  localparam int FCW  = $clog2(FREE_DEPTH + 1);
  localparam int TW   = FCW + 2;
  localparam int OMW  = IW + 2 * PW;
  localparam logic [PW-1:0]  SEG        = PW'(SEGMENT_SIZE);
  localparam logic [31:0]    POOL_LIMIT = 32'(SEGMENT_SIZE * MAX_SEGMENTS);
  localparam logic [OCW-1:0] OWN_N      = OCW'(OWNER_DEPTH);
  localparam logic [FCW-1:0] FREE_N     = FCW'(FREE_DEPTH);

  pra_pkg::state_t  state, state_next;
  pra_pkg::status_t stat_r;

  logic [IW-1:0]                 id_r;
  logic [pra_pkg::CNT_W-1:0]     cnt_r;
  logic [PW-1:0]                 req;
  logic                          fail;

  logic [OMW-1:0]                omem [OWNER_DEPTH];
  logic [OMW-1:0]                ordata;
  logic                          owe;
  logic [OWNER_DEPTH-1:0]        owner_valid;
  logic [OCW-1:0]                ocnt;
  logic                          ochk;
  logic [OAW-1:0]                oidx;
  logic                          hit_f, slot_f;
  logic [OAW-1:0]                hit_idx, slot_idx;
  logic [PW-1:0]                 hit_s, hit_e;

  logic [PW-1:0]                 fs_mem [FREE_DEPTH];
  logic [PW-1:0]                 fe_mem [FREE_DEPTH];
  logic [PW-1:0]                 fs_rd, fe_rd;
  logic [FAW-1:0]                faddr, fwaddr;
  logic                          fwe;
  logic [PW-1:0]                 fwd_s, fwd_e;
  logic [FCW-1:0]                free_entries;
  logic [FCW-1:0]                fcnt;
  logic                          fchk;
  logic [FAW-1:0]                fidx, pick_idx, k_r;
  logic                          pick_f, exact;
  logic [PW-1:0]                 pick_s, pick_e;
  logic [PW:0]                   best;

  logic [PW-1:0]                 pool_end;
  logic [PW-1:0]                 s_r, e_r;
  logic [PW-1:0]                 rem, pos;
  logic [PW:0]                   psize;
  logic [pra_pkg::PCS_W-1:0]     pieces;

  logic [IW-1:0]                 o_key;
  logic [PW-1:0]                 o_s, o_e;
  logic                          o_v, o_match;
  logic                          reuse;
  logic                          f_ok, f_exact, f_better;
  logic [PW-1:0]                 f_sz;
  logic [PW-1:0]                 place_s, place_e, place_span;
  logic                          pool_over;
  logic [PW-1:0]                 cnt_p, sp_d, sp_p;
  logic [TW-1:0]                 total;
  logic [FCW-1:0]                k_next;

  assign o_key   = ordata[OMW-1 -: IW];
  assign o_s     = ordata[2*PW-1 -: PW];
  assign o_e     = ordata[PW-1:0];
  assign o_v     = owner_valid[oidx];
  assign o_match = ochk && o_v && (o_key == id_r);
  assign reuse   = hit_f && (hit_e >= hit_s) && ((hit_e - hit_s) >= req);

  assign f_sz     = fe_rd - fs_rd;
  assign f_ok     = fchk && (fe_rd >= fs_rd);
  assign f_exact  = f_ok && (f_sz == req);
  assign f_better = f_ok && (f_sz > req) && ({1'b0, f_sz} < best);

  assign pool_over  = ({{(32-PW){1'b0}}, pool_end} + 32'(SEGMENT_SIZE)) > POOL_LIMIT;
  assign place_s    = pick_f ? pick_s : pool_end;
  assign place_e    = pick_f ? (exact ? pick_s + req : pick_e) : pool_end + SEG;
  assign place_span = place_e - place_s;

  assign cnt_p = ({1'b0, rem} < psize) ? rem : psize[PW-1:0];
  assign sp_d  = e_r - pos;
  assign sp_p  = ({1'b0, sp_d} < psize) ? sp_d : psize[PW-1:0];

  assign total  = TW'(free_entries) + TW'(hit_f) + TW'(pieces) - TW'(pick_f);
  assign k_next = FCW'(k_r) + FCW'(1);

  assign in_stall = (state != pra_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= pra_pkg::S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    fwe        = 1'b0;
    fwaddr     = '0;
    fwd_s      = '0;
    fwd_e      = '0;
    owe        = 1'b0;
    faddr      = fcnt[FAW-1:0];
    case (state)
      pra_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = (element_count > pra_pkg::MAX_PIECE) ? pra_pkg::S_DONE
                                                            : pra_pkg::S_OSCAN;
        end
      end
      pra_pkg::S_OSCAN: begin
        if (o_match || (ocnt == OWN_N && !ochk)) state_next = pra_pkg::S_DECIDE;
      end
      pra_pkg::S_DECIDE: begin
        if (reuse || (!hit_f && !slot_f)) state_next = pra_pkg::S_DONE;
        else                              state_next = pra_pkg::S_FSCAN;
      end
      pra_pkg::S_FSCAN: begin
        if (f_exact || (fcnt == free_entries && !fchk)) state_next = pra_pkg::S_PLACE;
      end
      pra_pkg::S_PLACE: begin
        if (!pick_f && pool_over)  state_next = pra_pkg::S_DONE;
        else if (place_span > req) state_next = pra_pkg::S_COUNT;
        else                       state_next = pra_pkg::S_CHECK;
      end
      pra_pkg::S_COUNT: begin
        if (rem == '0) state_next = pra_pkg::S_CHECK;
      end
      pra_pkg::S_CHECK: begin
        if (total > TW'(FREE_N)) state_next = pra_pkg::S_DONE;
        else if (pick_f)         state_next = pra_pkg::S_SHIFT_RD;
        else                     state_next = pra_pkg::S_APPEND;
      end
      pra_pkg::S_SHIFT_RD: begin
        faddr = k_next[FAW-1:0];
        if (k_next < free_entries) state_next = pra_pkg::S_SHIFT_WR;
        else                       state_next = pra_pkg::S_APPEND;
      end
      pra_pkg::S_SHIFT_WR: begin
        fwe        = 1'b1;
        fwaddr     = k_r;
        fwd_s      = fs_rd;
        fwd_e      = fe_rd;
        state_next = pra_pkg::S_SHIFT_RD;
      end
      pra_pkg::S_APPEND: begin
        fwe    = hit_f && (free_entries < FREE_N);
        fwaddr = free_entries[FAW-1:0];
        fwd_s  = hit_s;
        fwd_e  = hit_e;
        state_next = ((e_r - s_r) > req) ? pra_pkg::S_SPLIT : pra_pkg::S_OWRITE;
      end
      pra_pkg::S_SPLIT: begin
        if (pos < e_r) begin
          fwe    = (free_entries < FREE_N);
          fwaddr = free_entries[FAW-1:0];
          fwd_s  = pos;
          fwd_e  = pos + sp_p;
        end else begin
          state_next = pra_pkg::S_OWRITE;
        end
      end
      pra_pkg::S_OWRITE: begin
        owe        = 1'b1;
        state_next = pra_pkg::S_DONE;
      end
      pra_pkg::S_DONE: begin
        if (!out_valid || !out_stall) state_next = pra_pkg::S_IDLE;
      end
      default: state_next = pra_pkg::S_IDLE;
    endcase
  end

  // owner table: key, start, end
  always_ff @(posedge clk) begin
    if (owe) omem[slot_idx] <= {id_r, s_r, s_r + req};
    ordata <= omem[ocnt[OAW-1:0]];
  end

  // free list; entry zero is loaded by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      fs_mem[0] <= '0;
      fe_mem[0] <= SEG;
    end else if (fwe) begin
      fs_mem[fwaddr] <= fwd_s;
      fe_mem[fwaddr] <= fwd_e;
    end
    fs_rd <= fs_mem[faddr];
    fe_rd <= fe_mem[faddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owner_valid  <= '0;
      free_entries <= FCW'(1);
      pool_end     <= SEG;
      out_valid    <= 1'b0;
    end else begin
      if (state == pra_pkg::S_DONE && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (out_valid && !out_stall)                          out_valid <= 1'b0;
      case (state)
        pra_pkg::S_IDLE: begin
          if (in_valid) begin
            id_r   <= owner_id;
            cnt_r  <= element_count;
            req    <= PW'(pra_pkg::round_pow2(element_count));
            ocnt   <= '0;
            ochk   <= 1'b0;
            hit_f  <= 1'b0;
            slot_f <= 1'b0;
            fail   <= (element_count > pra_pkg::MAX_PIECE);
            stat_r <= pra_pkg::ST_TOO_LARGE;
          end
        end
        pra_pkg::S_OSCAN: begin
          if (ocnt < OWN_N) ocnt <= ocnt + OCW'(1);
          ochk <= (ocnt < OWN_N);
          oidx <= ocnt[OAW-1:0];
          if (o_match) begin
            hit_f   <= 1'b1;
            hit_idx <= oidx;
            hit_s   <= o_s;
            hit_e   <= o_e;
          end else if (ochk && !o_v && !slot_f) begin
            slot_f   <= 1'b1;
            slot_idx <= oidx;
          end
        end
        pra_pkg::S_DECIDE: begin
          s_r    <= hit_s;
          e_r    <= hit_e;
          fcnt   <= '0;
          fchk   <= 1'b0;
          pick_f <= 1'b0;
          exact  <= 1'b0;
          best   <= '1;
          if (hit_f) slot_idx <= hit_idx;
          if (reuse) begin
            stat_r <= pra_pkg::ST_REUSED;
            fail   <= 1'b0;
          end else if (!hit_f && !slot_f) begin
            stat_r <= pra_pkg::ST_TABLE_FULL;
            fail   <= 1'b1;
          end
        end
        pra_pkg::S_FSCAN: begin
          if (fcnt < free_entries) fcnt <= fcnt + FCW'(1);
          fchk <= (fcnt < free_entries);
          fidx <= fcnt[FAW-1:0];
          if (f_exact) begin
            pick_f   <= 1'b1;
            exact    <= 1'b1;
            pick_idx <= fidx;
            pick_s   <= fs_rd;
            pick_e   <= fe_rd;
          end else if (f_better) begin
            pick_f   <= 1'b1;
            pick_idx <= fidx;
            best     <= {1'b0, f_sz};
            pick_s   <= fs_rd;
            pick_e   <= fe_rd;
          end
        end
        pra_pkg::S_PLACE: begin
          s_r    <= place_s;
          e_r    <= place_e;
          rem    <= place_span - req;
          psize  <= {1'b0, req};
          pieces <= '0;
          if (pick_f) begin
            stat_r <= pra_pkg::ST_FREE_LIST;
            fail   <= 1'b0;
          end else if (pool_over) begin
            stat_r <= pra_pkg::ST_EXHAUSTED;
            fail   <= 1'b1;
          end else begin
            stat_r <= pra_pkg::ST_GROWN;
            fail   <= 1'b0;
          end
        end
        pra_pkg::S_COUNT: begin
          if (rem != '0) begin
            rem    <= rem - cnt_p;
            psize  <= psize << 1;
            pieces <= pieces + pra_pkg::PCS_W'(1);
          end
        end
        pra_pkg::S_CHECK: begin
          k_r <= pick_idx;
          if (total > TW'(FREE_N)) begin
            stat_r <= pra_pkg::ST_TABLE_FULL;
            fail   <= 1'b1;
          end
        end
        pra_pkg::S_SHIFT_RD: begin
          if (!(k_next < free_entries)) free_entries <= free_entries - FCW'(1);
        end
        pra_pkg::S_SHIFT_WR: begin
          k_r <= k_next[FAW-1:0];
        end
        pra_pkg::S_APPEND: begin
          if (hit_f && free_entries < FREE_N) free_entries <= free_entries + FCW'(1);
          if (stat_r == pra_pkg::ST_GROWN) pool_end <= e_r;
          pos   <= s_r + req;
          psize <= {1'b0, req};
        end
        pra_pkg::S_SPLIT: begin
          if (pos < e_r) begin
            pos   <= pos + sp_p;
            psize <= psize << 1;
            if (free_entries < FREE_N) free_entries <= free_entries + FCW'(1);
          end
        end
        pra_pkg::S_OWRITE: begin
          owner_valid[slot_idx] <= 1'b1;
          e_r <= s_r + req;
        end
        pra_pkg::S_DONE: begin
          if (!out_valid || !out_stall) begin
            range_start      <= fail ? '0 : s_r;
            range_end        <= fail ? '0 : e_r;
            granted_vertices <= fail ? '0 : cnt_r;
            granted_indices  <= fail ? '0 : cnt_r + (cnt_r >> 1);
            status           <= stat_r;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- src/pra_checker.sv -----
// pra_checker: port-level checks on the range allocator's result channel
// depends on pra_pkg; bound to pow2_range_allocator below
module pra_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [pra_pkg::POS_W-1:0]   range_start,
  input logic [pra_pkg::POS_W-1:0]   range_end,
  input logic [pra_pkg::CNT_W-1:0]   granted_vertices,
  input logic [pra_pkg::CNT_W-1:0]   granted_indices,
  input logic [pra_pkg::STAT_W-1:0]  status
);

  logic fail_code, alloc_code;
  assign fail_code  = (status == pra_pkg::ST_TOO_LARGE) || (status == pra_pkg::ST_TABLE_FULL)
                   || (status == pra_pkg::ST_EXHAUSTED);
  assign alloc_code = (status == pra_pkg::ST_FREE_LIST) || (status == pra_pkg::ST_GROWN);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(range_start) && $stable(status))
    else $error("stalled transaction changed");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && fail_code |-> range_start == '0 && range_end == '0
                               && granted_vertices == '0 && granted_indices == '0)
    else $error("failed transaction carries a range");

  a_pow2: assert property (@(posedge clk) disable iff (rst)
    out_valid && alloc_code |-> $countones(range_end - range_start) == 1
                                && (range_end - range_start) >= pra_pkg::POS_W'(64))
    else $error("new range is not a power of two");

  a_indices: assert property (@(posedge clk) disable iff (rst)
    out_valid && !fail_code |->
      granted_indices == granted_vertices + (granted_vertices >> 1))
    else $error("index count mismatch");

endmodule

bind pow2_range_allocator pra_checker u_pra_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .range_start      (range_start),
  .range_end        (range_end),
  .granted_vertices (granted_vertices),
  .granted_indices  (granted_indices),
  .status           (status)
);

// ----- sim/tb_pow2_range_allocator.sv -----
// tb_pow2_range_allocator: self-checking testbench for the power-of-two range allocator
// depends on pra_pkg and pow2_range_allocator; a queue-fed driver, a monitor and an
// in-bench allocator predictor that keeps its own owner table and free list
module tb_pow2_range_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SEG     = pra_pkg::SEGMENT_SIZE_DEF;
  localparam int NSEG    = pra_pkg::MAX_SEGMENTS_DEF;
  localparam int FDEPTH  = pra_pkg::FREE_DEPTH_DEF;
  localparam int ODEPTH  = pra_pkg::OWNER_DEPTH_DEF;
  localparam int N_RAND  = 400;

  typedef struct {
    logic [pra_pkg::ID_W-1:0]  id;
    logic [pra_pkg::CNT_W-1:0] cnt;
  } request_t;

  typedef struct {
    logic [pra_pkg::POS_W-1:0] rstart;
    logic [pra_pkg::POS_W-1:0] rend;
    logic [pra_pkg::CNT_W-1:0] verts;
    logic [pra_pkg::CNT_W-1:0] idxs;
    pra_pkg::status_t          st;
  } grant_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [pra_pkg::ID_W-1:0] owner_id = '0;
  logic [pra_pkg::CNT_W-1:0] element_count = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [pra_pkg::POS_W-1:0] range_start, range_end;
  logic [pra_pkg::CNT_W-1:0] granted_vertices, granted_indices;
  logic [pra_pkg::STAT_W-1:0] status;

  pow2_range_allocator u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .owner_id(owner_id), .element_count(element_count),
    .out_valid(out_valid), .out_stall(out_stall),
    .range_start(range_start), .range_end(range_end),
    .granted_vertices(granted_vertices), .granted_indices(granted_indices),
    .status(status)
  );

  always #10 clk = ~clk;

  // predictor state
  int unsigned fl_start [FDEPTH];
  int unsigned fl_end [FDEPTH];
  int unsigned fl_count;
  bit          own_valid [ODEPTH];
  logic [31:0] own_key [ODEPTH];
  int unsigned own_start [ODEPTH];
  int unsigned own_end [ODEPTH];
  int unsigned pool_top;

  request_t pending[$];
  grant_t   expected_grants[$];
  int errors = 0;
  int status_seen [6];
  int n_accepted = 0;
  int gap_left = 0;
  int stall_left = 0;
  bit quiet_in = 0;
  bit quiet_out = 0;
  request_t cur;
  grant_t   g;

  function automatic void fl_push(int unsigned s, int unsigned e);
    if (fl_count < FDEPTH) begin
      fl_start[fl_count] = s;
      fl_end[fl_count] = e;
      fl_count++;
    end
  endfunction

  function automatic grant_t allocate(logic [pra_pkg::ID_W-1:0] id,
                                      logic [pra_pkg::CNT_W-1:0] cnt);
    grant_t r;
    int unsigned need, s, e, sz, best, pieces, total, rem, piece, pos, psz;
    int hit, slot, pick;
    bit exact;
    r = '{default: '0, st: pra_pkg::ST_REUSED};
    hit = -1; slot = -1; pick = -1; best = 32'hFFFFFFFF; exact = 0;
    if (cnt > pra_pkg::MAX_PIECE) begin
      r.st = pra_pkg::ST_TOO_LARGE;
      return r;
    end
    need = pra_pkg::MIN_PIECE;
    while (need < cnt) need = need << 1;
    for (int i = 0; i < ODEPTH; i++)
      if (hit < 0 && own_valid[i] && own_key[i] == id) hit = i;
    if (hit >= 0 && own_end[hit] - own_start[hit] >= need) begin
      s = own_start[hit];
      e = own_end[hit];
      r.st = pra_pkg::ST_REUSED;
    end else begin
      if (hit >= 0) slot = hit;
      else begin
        for (int i = 0; i < ODEPTH; i++)
          if (slot < 0 && !own_valid[i]) slot = i;
        if (slot < 0) begin
          r.st = pra_pkg::ST_TABLE_FULL;
          return r;
        end
      end
      for (int i = 0; i < fl_count; i++) begin
        if (!exact && fl_end[i] >= fl_start[i]) begin
          sz = fl_end[i] - fl_start[i];
          if (sz == need) begin
            pick = i;
            exact = 1;
          end else if (sz > need && sz < best) begin
            pick = i;
            best = sz;
          end
        end
      end
      if (pick >= 0) begin
        s = fl_start[pick];
        e = exact ? s + need : fl_end[pick];
        r.st = pra_pkg::ST_FREE_LIST;
      end else begin
        if (pool_top + SEG > SEG * NSEG) begin
          r.st = pra_pkg::ST_EXHAUSTED;
          return r;
        end
        s = pool_top;
        e = pool_top + SEG;
        r.st = pra_pkg::ST_GROWN;
      end
      pieces = 0;
      if (e - s > need) begin
        rem = e - s - need;
        psz = need;
        while (rem > 0) begin
          piece = psz < rem ? psz : rem;
          rem -= piece;
          psz = psz << 1;
          pieces++;
        end
      end
      total = fl_count + (hit >= 0 ? 1 : 0) + pieces - (pick >= 0 ? 1 : 0);
      if (total > FDEPTH) begin
        r = '{default: '0, st: pra_pkg::ST_TABLE_FULL};
        return r;
      end
      if (pick >= 0) begin
        for (int k = pick; k + 1 < fl_count; k++) begin
          fl_start[k] = fl_start[k+1];
          fl_end[k] = fl_end[k+1];
        end
        fl_count--;
      end
      if (hit >= 0) fl_push(own_start[hit], own_end[hit]);
      if (r.st == pra_pkg::ST_GROWN) pool_top = e;
      if (e - s > need) begin
        pos = s + need;
        psz = need;
        while (pos < e) begin
          piece = psz < (e - pos) ? psz : (e - pos);
          fl_push(pos, pos + piece);
          pos += piece;
          psz = psz << 1;
        end
      end
      e = s + need;
      own_valid[slot] = 1;
      own_key[slot] = id;
      own_start[slot] = s;
      own_end[slot] = e;
    end
    r.rstart = s[pra_pkg::POS_W-1:0];
    r.rend = e[pra_pkg::POS_W-1:0];
    r.verts = cnt;
    r.idxs = cnt + cnt / 2;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_grants = {expected_grants, allocate(owner_id, element_count)};
        n_accepted++;
        if (n_accepted % 60 == 0) quiet_in = ~quiet_in;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending.size() > 0) begin
          cur = pending.pop_front();
          in_valid <= 1'b1;
          owner_id <= cur.id;
          element_count <= cur.cnt;
          gap_left <= quiet_in ? 0 : $urandom_range(0, 11);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_grants.size() == 0) begin
          $display("%0t: unexpected transaction, status %0d", $time, status);
          errors++;
        end else begin
          g = expected_grants.pop_front();
          status_seen[g.st]++;
          if (range_start !== g.rstart || range_end !== g.rend ||
              granted_vertices !== g.verts || granted_indices !== g.idxs ||
              status !== g.st) begin
            $display("%0t: expected start %0d end %0d verts %0d idx %0d status %0d",
                     $time, g.rstart, g.rend, g.verts, g.idxs, g.st);
            $display("%0t: actual   start %0d end %0d verts %0d idx %0d status %0d",
                     $time, range_start, range_end, granted_vertices,
                     granted_indices, status);
            errors++;
          end
        end
        stall_left = quiet_out ? 0 : $urandom_range(0, 11);
        if ($urandom_range(0, 40) == 0) quiet_out = ~quiet_out;
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  function automatic logic [pra_pkg::CNT_W-1:0] pick_count();
    int k;
    k = $urandom_range(0, 19);
    if (k == 0) return pra_pkg::CNT_W'($urandom_range(32769, 65535));
    if (k < 4) return pra_pkg::CNT_W'(64 << $urandom_range(0, 9));
    return pra_pkg::CNT_W'($urandom_range(0, 64 << $urandom_range(0, 9)));
  endfunction

  task automatic add(logic [pra_pkg::ID_W-1:0] id, logic [pra_pkg::CNT_W-1:0] cnt);
    request_t r;
    r.id = id;
    r.cnt = cnt;
    pending = {pending, r};
  endtask

  task automatic drain();
    while (pending.size() > 0 || in_valid || expected_grants.size() > 0)
      @(posedge clk);
  endtask

  logic [pra_pkg::ID_W-1:0] id_pool [80];

  initial begin
    fl_start[0] = 0;
    fl_end[0] = SEG;
    fl_count = 1;
    pool_top = SEG;
    foreach (own_valid[i]) own_valid[i] = 0;
    foreach (id_pool[i]) id_pool[i] = $urandom();
    id_pool[0] = '0;
    id_pool[1] = '1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed
    add(32'h0, 16'd0);
    add(32'hFFFF_FFFF, 16'd1);
    add(32'h0, 16'd64);
    add(32'h0, 16'd65);
    add(32'hFFFF_FFFF, 16'd32768);
    add(32'h1234_5678, 16'd32769);
    add(32'h1234_5678, 16'hFFFF);
    add(32'hA5A5_A5A5, 16'd32768);
    add(32'h5A5A_5A5A, 16'd16384);
    add(32'hFFFF_FFFF, 16'd100);
    add(32'h0, 16'd1000);
    add(32'h0, 16'd200);
    add(32'h7FFF_FFFF, 16'd127);
    add(32'h8000_0000, 16'd128);
    add(32'h1, 16'd4096);
    add(32'h2, 16'd24576);
    drain();

    for (int n = 0; n < N_RAND; n++) begin
      if ($urandom_range(0, 9) < 8) add(id_pool[$urandom_range(0, 79)], pick_count());
      else add($urandom(), pick_count());
      if (n == N_RAND / 2) drain();
    end
    drain();
    repeat (400) @(posedge clk);

    $display("%0d requests: reused %0d, free list %0d, grown %0d", n_accepted,
             status_seen[pra_pkg::ST_REUSED], status_seen[pra_pkg::ST_FREE_LIST],
             status_seen[pra_pkg::ST_GROWN]);
    $display("rejected: too large %0d, table full %0d, exhausted %0d",
             status_seen[pra_pkg::ST_TOO_LARGE], status_seen[pra_pkg::ST_TABLE_FULL],
             status_seen[pra_pkg::ST_EXHAUSTED]);
    if (errors == 0 && expected_grants.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("Mismatches found");
    $finish;
  end

endmodule
